// ----- hdl/aes128e_pkg.sv -----
// Shared types, S-box table and GF(2^8) helpers for the AES-128 encrypt core.
// No dependencies.
`default_nettype none

package aes128e_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ADD0 = 3'b010,
		ST_RUN  = 3'b100
	} aes_state_t;

	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX[x];
	endfunction

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

endpackage

`default_nettype wire

// ----- hdl/aes128e_ram.sv -----
// Generic single-write, single-read RAM with registered read data and read enable.
// No dependencies.
`default_nettype none

module aes128e_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/aes128e_lane.sv -----
// One column lane of an AES round: SubBytes, optional MixColumns, AddRoundKey.
// Depends on aes128e_pkg.
`default_nettype none

module aes128e_lane
	import aes128e_pkg::*;
(
	input  wire logic [31:0] col_in,   // row 0 in [31:24], already row-shifted
	input  wire logic        mix_en,
	input  wire logic [31:0] rkey,
	output logic      [31:0] col_out
);

	logic [7:0] sb  [4];
	logic [7:0] mx  [4];
	logic [7:0] all;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sb[r] = sbox(col_in[31-8*r -: 8]);
		end
		all = sb[0] ^ sb[1] ^ sb[2] ^ sb[3];
		for (int r = 0; r < 4; r++) begin
			mx[r] = sb[r] ^ xtime(sb[r] ^ sb[(r+1)%4]) ^ all;
		end
		for (int r = 0; r < 4; r++) begin
			col_out[31-8*r -: 8] = (mix_en ? mx[r] : sb[r]) ^ rkey[31-8*r -: 8];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/aes128_encrypt_block_core.sv -----
// AES-128 block encrypt core with a preloaded round-key store and four column lanes.
// Load beat: key written at the accepting edge. Encrypt beat: accept in idle, initial
// key addition, then one round a cycle up to output valid; a new beat is accepted only
// back in idle, after the final round. A result left untaken on the master side holds
// the final round. Reset (arst_n, async, active low) clears control state only; the key
// store is not cleared and must be loaded first.
// Depends on aes128e_pkg, aes128e_ram, aes128e_lane.
`default_nettype none

module aes128_encrypt_block_core
	import aes128e_pkg::*;
#(
	parameter int ROUNDS = 10
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave side
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,   // key_index[3:0], data_hi[67:4],
	                                          // data_lo[131:68], zero pad [135:132]
	input  wire logic         s_axis_tuser,   // func[0]: 0 load key, 1 encrypt
	// master side
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [127:0] m_axis_tdata    // cipher_hi[63:0], cipher_lo[127:64]
);

	localparam int KW = $clog2(ROUNDS + 1);
	localparam logic [KW-1:0] LAST_RND = KW'(ROUNDS);

	// input beat fields
	logic [3:0]  key_index;
	logic [63:0] data_hi;
	logic [63:0] data_lo;
	assign key_index = s_axis_tdata[3:0];
	assign data_hi   = s_axis_tdata[67:4];
	assign data_lo   = s_axis_tdata[131:68];

	aes_state_t      st_q;
	logic [KW-1:0]   rnd_q;      // number of the key on rk_data in ST_ADD0 and ST_RUN
	logic [127:0]    blk_q;      // working state, byte 0 in [127:120]
	logic [127:0]    cipher_q;
	logic            out_vld_q;

	logic            in_acc;
	logic            key_wr;
	logic            last_rnd;
	logic            stall;
	logic            rk_re;
	logic [KW-1:0]   rk_raddr;
	logic [127:0]    rk_data;
	logic [127:0]    rnd_out;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	// loads past the last round key are dropped
	assign key_wr        = in_acc && !s_axis_tuser && (key_index <= 4'(ROUNDS));

	assign last_rnd = (st_q == ST_RUN) && (rnd_q == LAST_RND);
	// final round waits while the output register still holds an untaken result
	assign stall    = last_rnd && out_vld_q && !m_axis_tready;

	// key read runs one round ahead; idle keeps key 0 addressed so it is ready
	// the cycle after an encrypt beat is accepted
	assign rk_re    = !stall;
	assign rk_raddr = ((st_q != ST_IDLE) && (rnd_q != LAST_RND)) ? rnd_q + KW'(1) : '0;

	aes128e_ram #(
		.WIDTH (128),
		.DEPTH (ROUNDS + 1)
	) u_key_store (
		.clk   (clk),
		.we    (key_wr),
		.waddr (key_index[KW-1:0]),
		.wdata ({data_hi, data_lo}),
		.re    (rk_re),
		.raddr (rk_raddr),
		.rdata (rk_data)
	);

	// four column lanes; ShiftRows is just the wiring into each lane:
	// row r of column c takes byte 4*((c+r)%4)+r of the current state
	for (genvar c = 0; c < 4; c++) begin : g_lane
		logic [31:0] col_in;
		for (genvar r = 0; r < 4; r++) begin : g_row
			assign col_in[31-8*r -: 8] = blk_q[127-8*(4*((c+r)%4)+r) -: 8];
		end
		aes128e_lane u_lane (
			.col_in  (col_in),
			.mix_en  (!last_rnd),
			.rkey    (rk_data[127-32*c -: 32]),
			.col_out (rnd_out[127-32*c -: 32])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			rnd_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser) begin
						st_q  <= ST_ADD0;
						rnd_q <= '0;
					end
				end
				ST_ADD0: begin
					st_q  <= ST_RUN;
					rnd_q <= KW'(1);
				end
				ST_RUN: begin
					if (last_rnd) begin
						if (!stall) begin
							st_q <= ST_IDLE;
						end
					end else begin
						rnd_q <= rnd_q + KW'(1);
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working state: initial key addition, then one round a cycle unless the final round stalls
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc && s_axis_tuser) begin
					blk_q <= {data_hi, data_lo};
				end
			end
			ST_ADD0: begin
				blk_q <= blk_q ^ rk_data;
			end
			ST_RUN: begin
				if (!stall) begin
					blk_q <= rnd_out;
				end
			end
			default: begin
				blk_q <= blk_q;
			end
		endcase
	end

	// output register: decouples the result from the next input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (last_rnd && !stall) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_rnd && !stall) begin
			cipher_q <= rnd_out;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {cipher_q[63:0], cipher_q[127:64]};

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for the AES-128 encrypt core: beats go in on the slave stream,
// ciphertext is predicted by a behavioural AES model and compared beat by beat.
// Depends on aes128e_pkg and aes128_encrypt_block_core.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import aes128e_pkg::*;

	localparam int ROUNDS       = 10;
	localparam int ENC_LATENCY  = ROUNDS + 1;      // accept to output valid
	localparam int RANDOM_ITEMS = 1100;            // mixed traffic with idling
	localparam int BURST_ITEMS  = 150;             // closing stretch, no idling
	localparam int TIMEOUT_NS   = 5_000_000;

	// what the slave-side tuser bit selects
	typedef enum logic {
		FUNC_LOAD    = 1'b0,
		FUNC_ENCRYPT = 1'b1
	} func_t;

	typedef struct packed {
		logic [63:0] cipher_lo;
		logic [63:0] cipher_hi;
	} cipher_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;   // key_index[3:0], data_hi[67:4], data_lo[131:68], pad
	logic         s_axis_tuser;   // func[0]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;   // cipher_hi[63:0], cipher_lo[127:64]

	// bench-side copy of the key store and the S-box built from first principles
	logic [127:0] round_keys [0:ROUNDS];
	logic [7:0]   sbox_tab   [0:255];
	cipher_t      cipher_expected [$];
	int           mismatch_count;
	bit           idling_on;

	aes128_encrypt_block_core #(
		.ROUNDS(ROUNDS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------- GF(2^8) maths

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= sh;
			sh = gf_dbl(sh);
		end
		return acc;
	endfunction

	// S-box = affine map of the multiplicative inverse (x^254), 0 maps to 0x63
	function automatic void build_sbox();
		logic [7:0] inv;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			for (int i = 0; i < 254; i++)
				inv = gf_mul(inv, 8'(x));
			if (x == 0)
				inv = 8'h00;
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
			        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sbox_tab[x] = s;
		end
	endfunction

	// ---------------------------------------------------------------- predictor

	// byte k of a 128-bit word sits at bits 127-8k downwards; byte 4c+r = row r, col c
	function automatic cipher_t aes_encrypt_block(input logic [127:0] plain);
		logic [7:0] st  [16];
		logic [7:0] tmp [16];
		logic [7:0] all;
		logic [127:0] res;
		cipher_t ct;
		for (int k = 0; k < 16; k++)
			st[k] = plain[127 - 8 * k -: 8] ^ round_keys[0][127 - 8 * k -: 8];
		for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
			// SubBytes and ShiftRows in one pass
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4 * c + r] = sbox_tab[st[4 * ((c + r) & 3) + r]];
			for (int c = 0; c < 4; c++) begin
				all = tmp[4 * c] ^ tmp[4 * c + 1] ^ tmp[4 * c + 2] ^ tmp[4 * c + 3];
				for (int r = 0; r < 4; r++) begin
					if (rnd < ROUNDS)
						st[4 * c + r] = tmp[4 * c + r] ^ all
						    ^ gf_dbl(tmp[4 * c + r] ^ tmp[4 * c + ((r + 1) & 3)]);
					else
						st[4 * c + r] = tmp[4 * c + r];   // last round: no MixColumns
				end
			end
			for (int k = 0; k < 16; k++)
				st[k] ^= round_keys[rnd][127 - 8 * k -: 8];
		end
		for (int k = 0; k < 16; k++)
			res[127 - 8 * k -: 8] = st[k];
		ct.cipher_hi = res[127:64];
		ct.cipher_lo = res[63:0];
		return ct;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return 64'h0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// drive one beat, wait for the handshake, then update the bench state
	task automatic send_beat(input func_t func, input logic [3:0] idx,
	                         input logic [63:0] hi, input logic [63:0] lo);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {4'b0000, lo, hi, idx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (func == FUNC_ENCRYPT)
			cipher_expected.push_back(aes_encrypt_block({hi, lo}));
		else if (idx <= ROUNDS)
			round_keys[idx] = {hi, lo};    // indices past the last round are dropped
	endtask

	task automatic sender_gap();
		if (idling_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// hold the sender off until every ciphertext has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (cipher_expected.size() != 0)
			@(posedge clk);
		repeat (ENC_LATENCY) @(posedge clk);
	endtask

	task automatic load_all_keys();
		for (int k = 0; k <= ROUNDS; k++) begin
			sender_gap();
			send_beat(FUNC_LOAD, 4'(k), rand_word(), rand_word());
		end
	endtask

	// one random beat or a full rekey; returns the number of beats sent
	task automatic random_beat(output int sent);
		int pick;
		pick = $urandom_range(0, 99);
		sent = 1;
		if (pick < 3) begin
			// full rekey with the pipeline empty
			wait_drained();
			load_all_keys();
			sent = ROUNDS + 1;
		end else if (pick < 6) begin
			// rekey straight behind in-flight blocks
			load_all_keys();
			sent = ROUNDS + 1;
		end else if (pick < 14) begin
			sender_gap();
			send_beat(FUNC_LOAD, 4'($urandom_range(0, 15)), rand_word(), rand_word());
		end else begin
			sender_gap();
			send_beat(FUNC_ENCRYPT, 4'($urandom_range(0, 15)), rand_word(), rand_word());
		end
	endtask

	// ---------------------------------------------------------------- tests

	// every key all ones, then plaintext extremes and a byte pattern
	task automatic test_key_load_extremes();
		for (int k = 0; k <= ROUNDS; k++)
			send_beat(FUNC_LOAD, 4'(k), '1, '1);
		send_beat(FUNC_ENCRYPT, 4'h0, 64'h0, 64'h0);
		send_beat(FUNC_ENCRYPT, 4'hf, '1, '1);
		send_beat(FUNC_ENCRYPT, 4'ha, 64'h0011223344556677, 64'h8899aabbccddeeff);
	endtask

	// loads beyond the last round must leave the store alone
	task automatic test_ignored_key_index();
		for (int k = ROUNDS + 1; k < 16; k++)
			send_beat(FUNC_LOAD, 4'(k), rand_word(), rand_word());
		send_beat(FUNC_ENCRYPT, 4'h5, 64'h0123456789abcdef, 64'hfedcba9876543210);
	endtask

	// first and last keys cleared while others stay set
	task automatic test_partial_rekey();
		send_beat(FUNC_LOAD, 4'h0, 64'h0, 64'h0);
		send_beat(FUNC_LOAD, 4'(ROUNDS), 64'h0, 64'h0);
		send_beat(FUNC_ENCRYPT, 4'hc, '1, 64'h0);
	endtask

	task automatic test_random_traffic();
		int count;
		int n;
		count = 0;
		idling_on = 1'b1;
		while (count < RANDOM_ITEMS) begin
			random_beat(n);
			count += n;
			if (count > RANDOM_ITEMS / 2 && count - n <= RANDOM_ITEMS / 2)
				wait_drained();
		end
	endtask

	// back-to-back traffic with the receiver always ready
	task automatic test_back_to_back();
		int count;
		int n;
		count = 0;
		idling_on = 1'b0;
		while (count < BURST_ITEMS) begin
			random_beat(n);
			count += n;
		end
	endtask

	// ---------------------------------------------------------------- receiver side

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idling_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// compare every ciphertext beat against the oldest prediction
	always @(posedge clk) begin
		cipher_t want;
		cipher_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.cipher_hi = m_axis_tdata[63:0];
			got.cipher_lo = m_axis_tdata[127:64];
			if (cipher_expected.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected beat, actual hi %h lo %h",
				         $time, got.cipher_hi, got.cipher_lo);
			end else begin
				want = cipher_expected.pop_front();
				if (got.cipher_hi !== want.cipher_hi) begin
					mismatch_count++;
					$display("%0t: cipher_hi expected %h actual %h",
					         $time, want.cipher_hi, got.cipher_hi);
				end
				if (got.cipher_lo !== want.cipher_lo) begin
					mismatch_count++;
					$display("%0t: cipher_lo expected %h actual %h",
					         $time, want.cipher_lo, got.cipher_lo);
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int guard;
		mismatch_count = 0;
		idling_on      = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tuser   = FUNC_LOAD;
		s_axis_tdata   = '0;
		build_sbox();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key store is undefined after reset: the first test loads every key
		test_key_load_extremes();
		test_ignored_key_index();
		test_partial_rekey();
		test_random_traffic();
		test_back_to_back();

		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (cipher_expected.size() != 0 && guard < 20 * ENC_LATENCY) begin
			@(posedge clk);
			guard++;
		end
		if (cipher_expected.size() != 0) begin
			mismatch_count += cipher_expected.size();
			$display("%0t: %0d ciphertext beats never arrived",
			         $time, cipher_expected.size());
		end
		repeat (2 * ENC_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
